>>> src/spab_pkg.sv
// Shared types, constants and the divider step function for the sprite pixel blender.
// Used by sprite_pixel_alpha_blend and its testbench. No dependencies.
package spab_pkg;

  // Pixel formats held in the depth mode register; the fourth code draws nothing.
  typedef enum logic [1:0] {
    MODE_8BIT  = 2'd0,
    MODE_16BIT = 2'd1,
    MODE_ARGB  = 2'd2
  } depth_mode_t;

  // Register indexes on the configuration port.
  localparam logic REG_DEPTH_MODE = 1'b0;
  localparam logic REG_KEY_COLOR  = 1'b1;

  localparam logic [1:0]  DEPTH_MODE_RESET = MODE_ARGB;
  localparam logic [15:0] KEY_COLOR_RESET  = 16'h0000;

  localparam logic [7:0]  MAX8 = 8'd255;
  // x/255 == (x * 0x8081) >> 23 for every x below 2**16.
  localparam logic [15:0] RECIP_255 = 16'h8081;

  localparam int NUM_CHAN = 3;

  // Long division of a 24-bit dividend by an 8-bit divisor, spread over stages.
  localparam int DIV_W      = 24;
  localparam int DIV_STEPS  = 6;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  // Stage map: entry products, alpha, divide, /255, output register.
  localparam int DIV_FIRST  = 2;
  localparam int DIV_LAST   = DIV_FIRST + DIV_STAGES - 1;
  localparam int Q_STAGE    = DIV_LAST + 1;
  localparam int OUT_STAGE  = Q_STAGE + 1;
  localparam int NUM_STAGES = OUT_STAGE + 1;

  // Control that travels with each word.
  typedef struct packed {
    logic        blend;
    logic        we;
    logic [31:0] pix;
  } ctl_t;

  // Partial remainder and dividend/quotient shift register of one divider.
  typedef struct packed {
    logic [7:0]       rem;
    logic [DIV_W-1:0] dq;
  } div_t;

  // Run DIV_STEPS restoring division steps; quotient bits shift in at the bottom.
  function automatic div_t div_steps(div_t d, logic [7:0] divisor);
    div_t       r;
    logic [9:0] diff;
    r = d;
    for (int i = 0; i < DIV_STEPS; i++) begin
      diff = {1'b0, r.rem, r.dq[DIV_W-1]} - {2'b00, divisor};
      if (!diff[9]) begin
        r.rem = diff[7:0];
        r.dq  = {r.dq[DIV_W-2:0], 1'b1};
      end else begin
        r.rem = {r.rem[6:0], r.dq[DIV_W-1]};
        r.dq  = {r.dq[DIV_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

>>> src/spab_if.sv
// Valid/ready channel interfaces for source/destination pixel pairs and blended results.
// Stand alone; no package needed.
interface spab_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_pixel;
  logic [31:0] dst_pixel;

  modport source(output valid, src_pixel, dst_pixel, input ready);
  modport sink(input valid, src_pixel, dst_pixel, output ready);
endinterface

interface spab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        write_enable;

  modport source(output valid, out_pixel, write_enable, input ready);
  modport sink(input valid, out_pixel, write_enable, output ready);
endinterface

>>> src/sprite_pixel_alpha_blend.sv
// Sprite pixel compositor: keyed copy in 8/16-bit modes, ARGB "over" blend in 32-bit mode.
// Depends on spab_pkg and the channel interfaces in spab_if.sv.
//
//   channel  | direction | word
//   item     | in        | src_pixel, dst_pixel
//   result   | out       | out_pixel, write_enable
//   APB      | in/out    | depth_mode (0x0), key_color (0x4)
//
// One pixel enters per cycle while the output is not stalled, and passes through eight
// register stages: products, alpha, the 24-bit divide by output alpha (six quotient bits
// per stage over four stages), /255 and the output register.
// Reset (rst, synchronous) empties the pipeline and loads depth_mode 2, key_color 0.
// A stage holds its word while the one after it is full and stalled; empty stages fill,
// so pixels are still taken while a finished result waits at the output.
module sprite_pixel_alpha_blend
  import spab_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  spab_in_if.sink           item,
  spab_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [1:0]  depth_mode;
  logic [15:0] key_color;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  ctl_t        ctl_in;
  ctl_t        ctl [OUT_STAGE];

  logic [7:0]  inv_sa_s;
  logic [15:0] p_s;
  logic [15:0] m1_s [NUM_CHAN];
  logic [15:0] m2_s [NUM_CHAN];

  logic [7:0]  oa_s [1:Q_STAGE];
  div_t        div_s [1:DIV_LAST][NUM_CHAN][2];

  logic [7:0]  q1_s [NUM_CHAN];
  logic [7:0]  qd_s [NUM_CHAN];

  logic [31:0] out_pixel;
  logic        out_we;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= DEPTH_MODE_RESET;
      key_color  <= KEY_COLOR_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DEPTH_MODE: depth_mode <= pwdata[1:0];
        REG_KEY_COLOR:  key_color  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEPTH_MODE: prdata = {30'b0, depth_mode};
      REG_KEY_COLOR:  prdata = {16'b0, key_color};
      default:        prdata = 32'b0;
    endcase
  end

  // Advance a stage when it is empty or the next stage advances
  always_comb begin
    adv[OUT_STAGE] = !vld[OUT_STAGE] || result.ready;
    for (int k = OUT_STAGE - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign item.ready = adv[0] && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= item.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Pick the copy result for keyed modes and transparent or unused cases
  always_comb begin
    ctl_in.blend = 1'b0;
    ctl_in.we    = 1'b0;
    ctl_in.pix   = item.dst_pixel;
    case (depth_mode)
      MODE_8BIT: begin
        if ({8'b0, item.src_pixel[7:0]} != key_color) begin
          ctl_in.we  = 1'b1;
          ctl_in.pix = {24'b0, item.src_pixel[7:0]};
        end
      end
      MODE_16BIT: begin
        if (item.src_pixel[15:0] != key_color) begin
          ctl_in.we  = 1'b1;
          ctl_in.pix = {16'b0, item.src_pixel[15:0]};
        end
      end
      MODE_ARGB: begin
        if (item.src_pixel[31:24] != 8'd0) begin
          ctl_in.blend = 1'b1;
          ctl_in.we    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Carry control alongside the data
  always_ff @(posedge clk) begin
    if (adv[0]) ctl[0] <= ctl_in;
    for (int k = 1; k < OUT_STAGE; k++) begin
      if (adv[k]) ctl[k] <= ctl[k-1];
    end
  end

  // Stage 0: alpha complement product and per-channel products
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      inv_sa_s <= MAX8 - item.src_pixel[31:24];
      p_s      <= {8'b0, MAX8 - item.src_pixel[31:24]} *
                  {8'b0, MAX8 - item.dst_pixel[31:24]};
      for (int c = 0; c < NUM_CHAN; c++) begin
        m1_s[c] <= {8'b0, item.src_pixel[31:24]} * {8'b0, item.src_pixel[c*8 +: 8]};
        m2_s[c] <= {8'b0, item.dst_pixel[31:24]} * {8'b0, item.dst_pixel[c*8 +: 8]};
      end
    end
  end

  // Output alpha: 255 - (255-sa)(255-da)/255, the quotient by reciprocal
  logic [31:0] p_scaled;
  assign p_scaled = {16'b0, p_s} * {16'b0, RECIP_255};

  // Destination term /255 by reciprocal
  // The destination quotient is at most 255*254, so its low 16 bits are the value.
  logic [31:0] qd_prod [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      qd_prod[c] = {16'b0, div_s[DIV_LAST][c][1].dq[15:0]} * {16'b0, RECIP_255};
    end
  end

  // Stages 1 to 6: alpha and divider set-up, divide by output alpha, then /255
  always_ff @(posedge clk) begin
    // Stage 1: output alpha and divider set-up
    if (adv[1]) begin
      oa_s[1] <= MAX8 - p_scaled[30:23];
      for (int c = 0; c < NUM_CHAN; c++) begin
        div_s[1][c][0] <= '{rem: 8'd0, dq: {8'b0, m1_s[c]}};
        div_s[1][c][1] <= '{rem: 8'd0, dq: {8'b0, m2_s[c]} * {16'b0, inv_sa_s}};
      end
    end
    // Stages 2..5: six quotient bits per stage, divisor is the output alpha
    for (int k = DIV_FIRST; k <= DIV_LAST; k++) begin
      if (adv[k]) begin
        oa_s[k] <= oa_s[k-1];
        for (int c = 0; c < NUM_CHAN; c++) begin
          for (int j = 0; j < 2; j++) begin
            div_s[k][c][j] <= div_steps(div_s[k-1][c][j], oa_s[k-1]);
          end
        end
      end
    end
    // Stage 6: hold both quotients, the destination one divided by 255
    if (adv[Q_STAGE]) begin
      oa_s[Q_STAGE] <= oa_s[DIV_LAST];
      for (int c = 0; c < NUM_CHAN; c++) begin
        q1_s[c] <= div_s[DIV_LAST][c][0].dq[7:0];
        qd_s[c] <= qd_prod[c][30:23];
      end
    end
  end

  // Stage 7: sum, saturate and assemble the result word
  logic [8:0]  chan_sum [NUM_CHAN];
  logic [23:0] rgb;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan_sum[c]    = {1'b0, q1_s[c]} + {1'b0, qd_s[c]};
      rgb[c*8 +: 8]  = chan_sum[c][8] ? MAX8 : chan_sum[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_STAGE]) begin
      out_pixel <= ctl[Q_STAGE].blend ? {oa_s[Q_STAGE], rgb} : ctl[Q_STAGE].pix;
      out_we    <= ctl[Q_STAGE].we;
    end
  end

  assign result.valid        = vld[OUT_STAGE];
  assign result.out_pixel    = out_pixel;
  assign result.write_enable = out_we;

  // A taken pixel occupies the entry stage on the next cycle
  a_entry_fill: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> vld[0])
    else $error("accepted pixel missing from entry stage");

  // Input back-pressure only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (&vld))
    else $error("input stalled with an empty stage");

  // Blended pixels never divide by zero alpha
  a_oa_nonzero: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && ctl[1].blend) |-> (oa_s[1] != 8'd0))
    else $error("zero output alpha on a blended pixel");

  // Blended pixels always write the destination
  a_blend_writes: assert property (@(posedge clk) disable iff (rst)
    (vld[Q_STAGE] && ctl[Q_STAGE].blend) |-> ctl[Q_STAGE].we)
    else $error("blended pixel without write enable");

endmodule

>>> verif/sprite_pixel_alpha_blend_tb.sv
// Self-checking testbench for sprite_pixel_alpha_blend: keyed copy and ARGB "over" blending.
// Drives pixel pairs and APB register writes, predicts every result word and checks it.
// Depends on spab_pkg, the channel interfaces in spab_if.sv and the block itself.
module sprite_pixel_alpha_blend_tb;
  import spab_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Code that the depth register can hold but that draws nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] ADDR_DEPTH_MODE = {REG_DEPTH_MODE, 2'b00};
  localparam logic [2:0] ADDR_KEY_COLOR  = {REG_KEY_COLOR, 2'b00};

  localparam int unsigned CH_MAX = 255;
  localparam int LATENCY = 8;
  localparam int NUM_DIRECTED = 22;
  localparam int PHASE_PIXELS = 90;
  localparam int PRESSURE_PIXELS = 60;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [31:0] pix;
    logic        we;
  } blend_word_t;

  // One directed pixel pair with its register setting; pix/we are used when typed is set.
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] key;
    logic [31:0] src;
    logic [31:0] dst;
    logic        typed;
    logic [31:0] pix;
    logic        we;
  } pixel_case_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spab_in_if  item_if();
  spab_out_if result_if();

  sprite_pixel_alpha_blend dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the registers, as the block holds them.
  logic [1:0]  cfg_mode = MODE_ARGB;
  logic [15:0] cfg_key  = 16'h0000;

  blend_word_t expected_words[$];
  int          err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold = 1'b0;

  pixel_case_t directed_cases [NUM_DIRECTED] = '{
    // after reset: blend mode, key zero
    '{MODE_ARGB,   16'h0000, 32'h00FFFFFF, 32'h12345678, 1'b1, 32'h12345678, 1'b0},
    '{MODE_ARGB,   16'h0000, 32'hFF112233, 32'h80445566, 1'b1, 32'hFF112233, 1'b1},
    '{MODE_ARGB,   16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{MODE_ARGB,   16'h0000, 32'h01000000, 32'h00000000, 1'b1, 32'h01000000, 1'b1},
    '{MODE_ARGB,   16'h0000, 32'h01FFFFFF, 32'h00FFFFFF, 1'b1, 32'h01FFFFFF, 1'b1},
    '{MODE_ARGB,   16'h0000, 32'h80FFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
    '{MODE_ARGB,   16'h0000, 32'h01000000, 32'hFF000000, 1'b0, 32'h0,        1'b0},
    // eight-bit keyed copy
    '{MODE_8BIT,   16'h0034, 32'hABCDEF34, 32'h11111111, 1'b1, 32'h11111111, 1'b0},
    '{MODE_8BIT,   16'h0034, 32'hABCDEF35, 32'h11111111, 1'b1, 32'h00000035, 1'b1},
    '{MODE_8BIT,   16'h0034, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h000000FF, 1'b1},
    // key above the byte range never matches an eight-bit source
    '{MODE_8BIT,   16'h1234, 32'h00000034, 32'hCAFEBABE, 1'b1, 32'h00000034, 1'b1},
    // sixteen-bit keyed copy
    '{MODE_16BIT,  16'h1234, 32'hFFFF1234, 32'h5A5A5A5A, 1'b1, 32'h5A5A5A5A, 1'b0},
    '{MODE_16BIT,  16'h1234, 32'h00001235, 32'h5A5A5A5A, 1'b1, 32'h00001235, 1'b1},
    '{MODE_16BIT,  16'hFFFF, 32'h0000FFFF, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
    '{MODE_16BIT,  16'hFFFF, 32'hFFFF0000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b1},
    // unused mode draws nothing
    '{MODE_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 32'h87654321, 1'b1, 32'h87654321, 1'b0},
    '{MODE_UNUSED, 16'hFFFF, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
    // eight-bit mode, key zero
    '{MODE_8BIT,   16'h0000, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{MODE_8BIT,   16'h0000, 32'hFFFFFF00, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
    // back to blending
    '{MODE_ARGB,   16'h0000, 32'h7F808080, 32'h40C0C0C0, 1'b0, 32'h0,        1'b0},
    '{MODE_ARGB,   16'h0000, 32'hFF000000, 32'h00FFFFFF, 1'b1, 32'hFF000000, 1'b1},
    '{MODE_ARGB,   16'h0000, 32'h01FFFFFF, 32'hFF000000, 1'b0, 32'h0,        1'b0}
  };

  // One colour channel of the "over" operator, truncating, saturated at full scale.
  function automatic logic [7:0] blend_chan(int unsigned sa, int unsigned sc, int unsigned da,
                                            int unsigned dc, int unsigned oa);
    int unsigned v;
    v = (sa * sc) / oa + ((da * dc * (CH_MAX - sa)) / oa) / CH_MAX;
    return (v > CH_MAX) ? 8'hFF : v[7:0];
  endfunction

  // Work out the new destination word for one pixel pair under the given registers.
  function automatic blend_word_t predict_pixel(input logic [1:0] mode, input logic [15:0] key,
                                                input logic [31:0] src, input logic [31:0] dst);
    blend_word_t w;
    int unsigned sa;
    int unsigned da;
    int unsigned oa;
    w.pix = dst;
    w.we  = 1'b0;
    case (mode)
      MODE_8BIT: begin
        if ({8'h00, src[7:0]} != key) begin
          w.pix = {24'h0, src[7:0]};
          w.we  = 1'b1;
        end
      end
      MODE_16BIT: begin
        if (src[15:0] != key) begin
          w.pix = {16'h0, src[15:0]};
          w.we  = 1'b1;
        end
      end
      MODE_ARGB: begin
        sa = 32'(src[31:24]);
        if (sa != 0) begin
          da = 32'(dst[31:24]);
          oa = CH_MAX - ((CH_MAX - sa) * (CH_MAX - da)) / CH_MAX;
          w.pix = {oa[7:0],
                   blend_chan(sa, 32'(src[23:16]), da, 32'(dst[23:16]), oa),
                   blend_chan(sa, 32'(src[15:8]), da, 32'(dst[15:8]), oa),
                   blend_chan(sa, 32'(src[7:0]), da, 32'(dst[7:0]), oa)};
          w.we = 1'b1;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // Alpha values weighted towards the corners of the blend.
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'hFE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random pixel pair shaped to the current mode: key hits in keyed modes, edge alphas in blend.
  function automatic logic [63:0] random_pair();
    logic [31:0] src;
    logic [31:0] dst;
    src = $urandom;
    dst = $urandom;
    if (cfg_mode == MODE_ARGB) begin
      src[31:24] = pick_alpha();
      dst[31:24] = pick_alpha();
    end else if ($urandom_range(2) == 0) begin
      if (cfg_mode == MODE_8BIT) src[7:0] = cfg_key[7:0];
      else src[15:0] = cfg_key;
    end
    return {src, dst};
  endfunction

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("sprite_pixel_alpha_blend_tb: errors");
    $finish;
  end

  // Result side: check each word taken, then decide ready for the next edge.
  initial begin : result_sink
    blend_word_t exp_w;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_pixel %h write_enable %b",
                 result_if.out_pixel, result_if.write_enable);
          err_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (result_if.out_pixel !== exp_w.pix) begin
            $error("out_pixel: expected %h, got %h", exp_w.pix, result_if.out_pixel);
            err_count++;
          end
          if (result_if.write_enable !== exp_w.we) begin
            $error("write_enable: expected %b, got %b", exp_w.we, result_if.write_enable);
            err_count++;
          end
        end
      end
      if (long_hold) result_if.ready <= 1'b0;
      else result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold the receiver off for a fixed stretch while the sender keeps offering.
  task automatic hold_receiver(input int cycles);
    long_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    long_hold <= 1'b0;
  endtask

  // Offer one pixel pair, with random idle cycles first; record its expected word on accept.
  task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst,
                            input logic typed, input blend_word_t typed_w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid     <= 1'b1;
    item_if.src_pixel <= src;
    item_if.dst_pixel <= dst;
    do @(posedge clk); while (!item_if.ready);
    if (typed) expected_words = {expected_words, typed_w};
    else expected_words = {expected_words, predict_pixel(cfg_mode, cfg_key, src, dst)};
  endtask

  // Drop valid and wait for every outstanding word to come back.
  task automatic drain_block();
    item_if.valid <= 1'b0;
    wait (expected_words.size() == 0);
    @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_DEPTH_MODE) cfg_mode = data[1:0];
    else cfg_key = data[15:0];
  endtask

  // Drain, then load both registers; unused upper bits of the data carry noise.
  task automatic set_config(input logic [1:0] mode, input logic [15:0] key);
    drain_block();
    write_reg(ADDR_DEPTH_MODE, {30'($urandom), mode});
    write_reg(ADDR_KEY_COLOR, {16'($urandom), key});
  endtask

  // Main sequence
  initial begin : stimulus
    logic [63:0] pair;
    logic [1:0]  nmode;
    logic [15:0] nkey;
    rst               <= 1'b1;
    item_if.valid     <= 1'b0;
    item_if.src_pixel <= 32'h0;
    item_if.dst_pixel <= 32'h0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= 3'h0;
    pwdata            <= 32'h0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, starting from the reset register values
    foreach (directed_cases[i]) begin
      if (directed_cases[i].mode != cfg_mode || directed_cases[i].key != cfg_key)
        set_config(directed_cases[i].mode, directed_cases[i].key);
      send_pixel(directed_cases[i].src, directed_cases[i].dst, directed_cases[i].typed,
                 '{pix: directed_cases[i].pix, we: directed_cases[i].we});
    end

    // Back-pressure: receiver held off long enough that the input stalls
    set_config(MODE_ARGB, 16'h0000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      hold_receiver(HOLD_OFF_CYCLES);
    join_none
    repeat (PRESSURE_PIXELS) begin
      pair = random_pair();
      send_pixel(pair[63:32], pair[31:0], 1'b0, '0);
    end
    drain_block();

    // Random phases over register settings and idling patterns
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin nmode = MODE_ARGB;   nkey = 16'h0000; end
        1: begin nmode = MODE_8BIT;   nkey = 16'h0000; end
        2: begin nmode = MODE_8BIT;   nkey = 16'h00FF; end
        3: begin nmode = MODE_16BIT;  nkey = 16'hFFFF; end
        4: begin nmode = MODE_16BIT;  nkey = 16'($urandom); end
        5: begin nmode = MODE_UNUSED; nkey = 16'($urandom); end
        6: begin nmode = MODE_ARGB;   nkey = 16'hFFFF; end
        default: begin nmode = MODE_8BIT; nkey = 16'($urandom_range(255)); end
      endcase
      set_config(nmode, nkey);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // pause the sender until the block has emptied
        if (n == PHASE_PIXELS / 2) drain_block();
        pair = random_pair();
        send_pixel(pair[63:32], pair[31:0], 1'b0, '0);
      end
    end

    // Wind down
    recv_stall_pct = 0;
    drain_block();
    repeat (LATENCY + 4) @(posedge clk);
    if (err_count == 0) begin
      $display("sprite_pixel_alpha_blend_tb: clean");
    end else begin
      $display("sprite_pixel_alpha_blend_tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/spab_pkg.sv
src/spab_if.sv
src/sprite_pixel_alpha_blend.sv
verif/sprite_pixel_alpha_blend_tb.sv
